@@ rtl/core/eltok_pkg.sv @@
// shared types, constants and character classes for the expression tokenizer
// no dependencies
package eltok_pkg;

  localparam int KIND_W      = 4;
  localparam int START_W     = 16;
  localparam int LEN_W       = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEN_W-1:0] EOF_LENGTH = LEN_W'(3);
  localparam logic [LEN_W-1:0] OP_LENGTH  = LEN_W'(1);

  localparam logic [7:0] CHAR_NUL        = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_TAB        = 8'h09;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CHAR_PLUS       = 8'h2B;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_STAR       = 8'h2A;
  localparam logic [7:0] CHAR_SLASH      = 8'h2F;
  localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
  localparam logic [7:0] CHAR_SEMI       = 8'h3B;
  localparam logic [7:0] CHAR_LPAREN     = 8'h28;
  localparam logic [7:0] CHAR_RPAREN     = 8'h29;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  localparam int PRINT_LEN = 5;
  localparam int LET_LEN   = 3;
  localparam logic [7:0] WORD_PRINT [PRINT_LEN] = '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74};
  localparam logic [7:0] WORD_LET   [LET_LEN]   = '{8'h6C, 8'h65, 8'h74};

  typedef enum logic [KIND_W-1:0] {
    KIND_INT    = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_PLUS   = 4'd2,
    KIND_MINUS  = 4'd3,
    KIND_STAR   = 4'd4,
    KIND_SLASH  = 4'd5,
    KIND_EQUAL  = 4'd6,
    KIND_SEMI   = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_PRINT  = 4'd10,
    KIND_LET    = 4'd11,
    KIND_EOF    = 4'd12,
    KIND_ERROR  = 4'd13
  } token_kind_t;

  typedef struct packed {
    token_kind_t        kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } token_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic token_kind_t op_kind(input logic [7:0] c);
    token_kind_t k;
    case (c)
      CHAR_PLUS:   k = KIND_PLUS;
      CHAR_MINUS:  k = KIND_MINUS;
      CHAR_STAR:   k = KIND_STAR;
      CHAR_EQUAL:  k = KIND_EQUAL;
      CHAR_SEMI:   k = KIND_SEMI;
      CHAR_LPAREN: k = KIND_LPAREN;
      CHAR_RPAREN: k = KIND_RPAREN;
      default:     k = KIND_ERROR;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/expression_language_tokenizer_top.sv @@
// top level of the streaming expression tokenizer
// depends on eltok_pkg, eltok_scan and eltok_queue
//
// Takes one source byte per transfer and returns tokens (kind, start offset, length, last
// flag) as they complete. A byte is taken every cycle while the result queue has room;
// a byte that both closes a pending token and forms one of its own yields two tokens,
// and the single-transfer output side gives them one at a time, so the input slows to
// match while results wait. A byte's first token passes through the input register,
// then the result queue. The byte scan is one shallow step per cycle unless stalled.
module expression_language_tokenizer_top import eltok_pkg::*; #(
  parameter int OFFSET_BITS = 16,
  parameter int MAX_LEXEME  = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         source_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  token_kind,
  output logic [START_W-1:0] token_start,
  output logic [LEN_W-1:0]   token_length,
  output logic               run_last
);

  token_push_t push;
  token_t      head;
  logic        room;

  eltok_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_LEXEME  (MAX_LEXEME)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .source_char (source_char),
    .in_stall    (in_stall),
    .room        (room),
    .push        (push)
  );

  eltok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign run_last     = head.last;

endmodule

@@ rtl/core/eltok_scan.sv @@
// input register, scan state and per-character token logic
// depends on eltok_pkg
module eltok_scan import eltok_pkg::*; #(
  parameter int OFFSET_BITS = 16,
  parameter int MAX_LEXEME  = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  source_char,
  output logic        in_stall,
  input  logic        room,
  output token_push_t push
);

  localparam int RUN_W = $clog2(MAX_LEXEME + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_LEXEME);
  localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);
  localparam logic [RUN_W-1:0] RUN_PRINT = RUN_W'(PRINT_LEN);
  localparam logic [RUN_W-1:0] RUN_LET = RUN_W'(LET_LEN);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_INT     = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_SLASH   = 3'd3,
    MODE_COMMENT = 3'd4
  } mode_t;

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] token_begin, token_begin_next;
  logic [RUN_W-1:0]       run_count, run_count_next;
  logic [OFFSET_BITS-1:0] char_offset, char_offset_next;
  logic [1:0]             keyword_hope, keyword_hope_next;
  logic                   in_full;
  logic [7:0]             in_char;

  logic             process;
  logic             consumed;
  logic             close_valid, new_valid;
  token_t           close_tok, new_tok;
  logic [1:0]       hope_cont;
  logic [RUN_W-1:0] run_up;
  logic             ident_char;

  assign process  = in_full && room;
  assign in_stall = in_full && !room;

  assign ident_char = is_alpha(in_char) || is_digit(in_char) || (in_char == CHAR_UNDERSCORE);
  assign run_up = (run_count < RUN_MAX) ? run_count + RUN_ONE : run_count;

  // keyword candidates surviving one more identifier character
  always_comb begin
    hope_cont[0] = keyword_hope[0] && (run_count < RUN_PRINT)
                   && (in_char == WORD_PRINT[run_count[2:0]]);
    hope_cont[1] = keyword_hope[1] && (run_count < RUN_LET)
                   && (in_char == WORD_LET[run_count[1:0]]);
  end

  always_comb begin
    mode_next         = mode;
    token_begin_next  = token_begin;
    run_count_next    = run_count;
    keyword_hope_next = keyword_hope;
    char_offset_next  = (char_offset != '1) ? char_offset + OFFSET_BITS'(1) : char_offset;
    consumed          = 1'b0;
    close_valid       = 1'b0;
    close_tok.kind    = KIND_INT;
    close_tok.start   = START_W'(token_begin);
    close_tok.length  = LEN_W'(run_count);
    close_tok.last    = 1'b0;
    new_valid         = 1'b0;
    new_tok.kind      = op_kind(in_char);
    new_tok.start     = START_W'(char_offset);
    new_tok.length    = OP_LENGTH;
    new_tok.last      = 1'b1;

    // close or continue the pending token
    case (mode)
      MODE_INT: begin
        if (is_digit(in_char)) begin
          run_count_next = run_up;
          consumed = 1'b1;
        end else begin
          close_valid = 1'b1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (ident_char) begin
          keyword_hope_next = hope_cont;
          run_count_next = run_up;
          consumed = 1'b1;
        end else begin
          close_valid = 1'b1;
          mode_next = MODE_IDLE;
          if ((run_count == RUN_PRINT) && keyword_hope[0]) begin
            close_tok.kind = KIND_PRINT;
          end else if ((run_count == RUN_LET) && keyword_hope[1]) begin
            close_tok.kind = KIND_LET;
          end else begin
            close_tok.kind = KIND_IDENT;
          end
        end
      end
      MODE_SLASH: begin
        if (in_char == CHAR_SLASH) begin
          mode_next = MODE_COMMENT;
          consumed = 1'b1;
        end else begin
          close_valid = 1'b1;
          close_tok.kind = KIND_SLASH;
          close_tok.length = OP_LENGTH;
          mode_next = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        mode_next = MODE_IDLE;
        if (in_char != CHAR_NUL) begin
          consumed = 1'b1;
          if (in_char != CHAR_NEWLINE) begin
            mode_next = MODE_COMMENT;
          end
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    // start of a new token from this character
    if (!consumed) begin
      if (in_char == CHAR_NUL) begin
        new_valid         = 1'b1;
        new_tok.kind      = KIND_EOF;
        new_tok.length    = EOF_LENGTH;
        mode_next         = MODE_IDLE;
        token_begin_next  = '0;
        run_count_next    = '0;
        char_offset_next  = '0;
        keyword_hope_next = 2'b11;
      end else if (is_space(in_char)) begin
        mode_next = mode_next;
      end else if (is_digit(in_char)) begin
        mode_next        = MODE_INT;
        token_begin_next = char_offset;
        run_count_next   = RUN_ONE;
      end else if (is_alpha(in_char) || (in_char == CHAR_UNDERSCORE)) begin
        mode_next            = MODE_IDENT;
        token_begin_next     = char_offset;
        run_count_next       = RUN_ONE;
        keyword_hope_next[0] = (in_char == WORD_PRINT[0]);
        keyword_hope_next[1] = (in_char == WORD_LET[0]);
      end else if (in_char == CHAR_SLASH) begin
        mode_next        = MODE_SLASH;
        token_begin_next = char_offset;
      end else begin
        new_valid = 1'b1;
      end
    end
  end

  always_comb begin
    push.count = 2'd0;
    push.tok0  = new_tok;
    push.tok1  = new_tok;
    if (process) begin
      push.count = {1'b0, close_valid} + {1'b0, new_valid};
      if (close_valid) begin
        push.tok0      = close_tok;
        push.tok0.last = !new_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      token_begin  <= '0;
      run_count    <= '0;
      char_offset  <= '0;
      keyword_hope <= 2'b11;
      in_full      <= 1'b0;
    end else begin
      if (process) begin
        mode         <= mode_next;
        token_begin  <= token_begin_next;
        run_count    <= run_count_next;
        char_offset  <= char_offset_next;
        keyword_hope <= keyword_hope_next;
      end
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (process) begin
        in_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_char <= source_char;
    end
  end

endmodule

@@ rtl/core/eltok_queue.sv @@
// result queue taking up to two tokens per cycle and giving one per transfer
// depends on eltok_pkg
module eltok_queue import eltok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  token_push_t push,
  output logic        room,
  output logic        out_valid,
  input  logic        out_stall,
  output token_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  token_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   rd_ptr, wr_ptr, wr_ptr_plus;
  logic [CNT_W-1:0]   count, count_next;
  logic               pop;

  assign out_valid   = (count != '0);
  assign pop         = out_valid && !out_stall;
  assign room        = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign head        = entries[rd_ptr];
  assign wr_ptr_plus = wr_ptr + PTR_W'(1);
  assign count_next  = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.tok0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus] <= push.tok1;
    end
  end

endmodule

@@ rtl/core/eltok_checker.sv @@
// port-level checks for the expression tokenizer, bound to the top level
// depends on eltok_pkg and expression_language_tokenizer_top
module eltok_checker import eltok_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [KIND_W-1:0]  token_kind,
  input logic [START_W-1:0] token_start,
  input logic [LEN_W-1:0]   token_length,
  input logic               run_last
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(token_start)
      && $stable(token_length) && $stable(run_last))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  // end of source closes the run
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_EOF) |-> (token_length == EOF_LENGTH) && run_last)
    else $error("eof token malformed");

  // single-character tokens are one byte long
  a_op_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((token_kind == KIND_PLUS) || (token_kind == KIND_MINUS)
      || (token_kind == KIND_STAR) || (token_kind == KIND_SLASH)
      || (token_kind == KIND_EQUAL) || (token_kind == KIND_SEMI)
      || (token_kind == KIND_LPAREN) || (token_kind == KIND_RPAREN)
      || (token_kind == KIND_ERROR)) |-> (token_length == OP_LENGTH))
    else $error("operator token length wrong");

endmodule

bind expression_language_tokenizer_top eltok_checker u_eltok_checker (.*);

@@ sim/eltok_token_checker.sv @@
`timescale 1ns / 100ps
// token checker for the expression tokenizer: predicts tokens from accepted source bytes
// and compares them with every result transfer; depends on eltok_pkg
module eltok_token_checker import eltok_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         source_char,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [KIND_W-1:0]  token_kind,
  input  logic [START_W-1:0] token_start,
  input  logic [LEN_W-1:0]   token_length,
  input  logic               run_last,
  output int                 fail_count,
  output int                 pending
);

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_INT,
    SCAN_IDENT,
    SCAN_SLASH,
    SCAN_COMMENT
  } scan_state_t;

  localparam logic [LEN_W-1:0]   LEN_MAX    = LEN_W'(63);
  localparam logic [START_W-1:0] OFFSET_MAX = '1;

  scan_state_t        scan_state;
  logic [START_W-1:0] lexeme_start;
  logic [START_W-1:0] byte_offset;
  logic [LEN_W-1:0]   lexeme_len;
  logic [1:0]         keyword_live;
  token_t             expected_tokens[$];
  int                 mismatch_total = 0;
  int                 waiting_count = 0;

  assign fail_count = mismatch_total;
  assign pending    = waiting_count;

  function automatic logic is_num(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic token_kind_t single_kind(input logic [7:0] c);
    case (c)
      CHAR_PLUS:   return KIND_PLUS;
      CHAR_MINUS:  return KIND_MINUS;
      CHAR_STAR:   return KIND_STAR;
      CHAR_EQUAL:  return KIND_EQUAL;
      CHAR_SEMI:   return KIND_SEMI;
      CHAR_LPAREN: return KIND_LPAREN;
      CHAR_RPAREN: return KIND_RPAREN;
      default:     return KIND_ERROR;
    endcase
  endfunction

  task automatic restart_scan();
    scan_state   = SCAN_IDLE;
    lexeme_start = '0;
    lexeme_len   = '0;
    byte_offset  = '0;
    keyword_live = 2'b11;
  endtask

  task automatic track_keywords(input logic [7:0] c);
    if (lexeme_len >= PRINT_LEN) begin
      keyword_live[0] = 1'b0;
    end else if (c != WORD_PRINT[lexeme_len]) begin
      keyword_live[0] = 1'b0;
    end
    if (lexeme_len >= LET_LEN) begin
      keyword_live[1] = 1'b0;
    end else if (c != WORD_LET[lexeme_len]) begin
      keyword_live[1] = 1'b0;
    end
  endtask

  task automatic lengthen();
    if (lexeme_len != LEN_MAX) lexeme_len++;
  endtask

  task automatic add_token(input token_kind_t kind, input logic [START_W-1:0] start,
                           input logic [LEN_W-1:0] len);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic scan_byte(input logic [7:0] c);
    int          first_new;
    logic        taken;
    logic        ended;
    token_kind_t k;
    token_t      t;
    first_new = expected_tokens.size();
    taken     = 1'b0;
    ended     = 1'b0;
    case (scan_state)
      SCAN_INT: begin
        if (is_num(c)) begin
          lengthen();
          taken = 1'b1;
        end else begin
          add_token(KIND_INT, lexeme_start, lexeme_len);
          scan_state = SCAN_IDLE;
        end
      end
      SCAN_IDENT: begin
        if (is_letter(c) || is_num(c) || c == CHAR_UNDERSCORE) begin
          track_keywords(c);
          lengthen();
          taken = 1'b1;
        end else begin
          k = KIND_IDENT;
          if (lexeme_len == PRINT_LEN && keyword_live[0]) k = KIND_PRINT;
          else if (lexeme_len == LET_LEN && keyword_live[1]) k = KIND_LET;
          add_token(k, lexeme_start, lexeme_len);
          scan_state = SCAN_IDLE;
        end
      end
      SCAN_SLASH: begin
        if (c == CHAR_SLASH) begin
          scan_state = SCAN_COMMENT;
          taken = 1'b1;
        end else begin
          add_token(KIND_SLASH, lexeme_start, OP_LENGTH);
          scan_state = SCAN_IDLE;
        end
      end
      SCAN_COMMENT: begin
        if (c != CHAR_NUL) begin
          if (c == CHAR_NEWLINE) scan_state = SCAN_IDLE;
          taken = 1'b1;
        end else begin
          scan_state = SCAN_IDLE;
        end
      end
      default: scan_state = SCAN_IDLE;
    endcase

    if (!taken) begin
      if (c == CHAR_NUL) begin
        add_token(KIND_EOF, byte_offset, EOF_LENGTH);
        restart_scan();
        ended = 1'b1;
      end else if (is_blank(c)) begin
      end else if (is_num(c)) begin
        scan_state   = SCAN_INT;
        lexeme_start = byte_offset;
        lexeme_len   = LEN_W'(1);
      end else if (is_letter(c) || c == CHAR_UNDERSCORE) begin
        scan_state   = SCAN_IDENT;
        lexeme_start = byte_offset;
        lexeme_len   = '0;
        keyword_live = 2'b11;
        track_keywords(c);
        lexeme_len   = LEN_W'(1);
      end else if (c == CHAR_SLASH) begin
        scan_state   = SCAN_SLASH;
        lexeme_start = byte_offset;
      end else begin
        add_token(single_kind(c), byte_offset, OP_LENGTH);
      end
    end

    if (!ended && byte_offset != OFFSET_MAX) byte_offset++;
    if (expected_tokens.size() > first_new) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_total++;
    if (mismatch_total <= 50) $display("%0t token check: %s", $time, what);
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("token kind %0d start %0d with none expected",
                                token_kind, token_start));
    end else begin
      want = expected_tokens.pop_front();
      if (token_kind != want.kind)
        report_mismatch($sformatf("kind got %0d expected %0d", token_kind, want.kind));
      if (token_start != want.start)
        report_mismatch($sformatf("start got %0d expected %0d", token_start, want.start));
      if (token_length != want.length)
        report_mismatch($sformatf("length got %0d expected %0d", token_length, want.length));
      if (run_last != want.last)
        report_mismatch($sformatf("last got %0d expected %0d", run_last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_scan();
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) check_token();
      if (in_valid && !in_stall) scan_byte(source_char);
    end
    waiting_count = expected_tokens.size();
  end

endmodule

@@ sim/expression_language_tokenizer_top_tb.sv @@
`timescale 1ns / 100ps
// testbench top for the expression tokenizer: drives source bytes and result stalls
// depends on eltok_pkg, expression_language_tokenizer_top and eltok_token_checker
module expression_language_tokenizer_top_tb;
  import eltok_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         source_char;
  logic               out_valid;
  logic               out_stall;
  logic [KIND_W-1:0]  token_kind;
  logic [START_W-1:0] token_start;
  logic [LEN_W-1:0]   token_length;
  logic               run_last;
  int                 fail_count;
  int                 pending;
  bit                 gaps_on = 1'b1;
  int                 bytes_sent = 0;

  string near_words[10] = '{"prin", "printt", "Print", "pr1nt", "le", "lett", "LET",
                            "let_", "_let", "printer"};
  string punct = "!#$%&,.:<>?@[]^`{|}~\"'\\";
  string ops = "+-*/=;()";

  expression_language_tokenizer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_char  (source_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last)
  );

  eltok_token_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .source_char  (source_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("expression_language_tokenizer_top_tb: FAIL");
    $finish;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    source_char <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] word_char(input bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return CHAR_UNDERSCORE;
    return 8'(8'h30 + r - 53);
  endfunction

  task automatic send_random_lexeme();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_byte(8'(8'h30 + $urandom_range(0, 9)));
    end else if (pick < 44) begin
      case ($urandom_range(0, 3))
        0: send_text("print");
        1: send_text("let");
        2: send_text(near_words[$urandom_range(0, 9)]);
        default: begin
          n = ($urandom_range(0, 12) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 7);
          for (int i = 0; i < n; i++) send_byte(word_char(i == 0));
        end
      endcase
    end else if (pick < 64) begin
      send_byte(ops[$urandom_range(0, ops.len() - 1)]);
    end else if (pick < 72) begin
      send_text("//");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(1, 255));
        if (c == CHAR_NEWLINE) c = 8'h23;
        send_byte(c);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_byte(CHAR_NUL);
      end else begin
        send_byte(CHAR_NEWLINE);
      end
    end else if (pick < 86) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(8, 13));
        send_byte(c == 8'h08 ? CHAR_SPACE : c);
      end
    end else if (pick < 92) begin
      if ($urandom_range(0, 1) == 0) send_byte(8'($urandom_range(128, 255)));
      else send_byte(punct[$urandom_range(0, punct.len() - 1)]);
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(CHAR_NUL);
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    source_char <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // every operator, both keywords, blanks, a high byte, lone slash, end inside a comment
    send_text("print(x+1)");
    send_text(";let=9-*/");
    for (int c = 9; c <= 13; c++) send_byte(8'(c));
    send_byte(8'h80);
    send_text("//");
    send_byte(CHAR_NUL);
    drain_results();

    gaps_on = 1'b1;
    while (bytes_sent < 700) begin
      if ($urandom_range(0, 29) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (bytes_sent >= 560) gaps_on = 1'b0;
      send_random_lexeme();
    end
    send_byte(CHAR_NUL);
    drain_results();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("expression_language_tokenizer_top_tb: PASS");
    end else begin
      $display("expression_language_tokenizer_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/eltok_pkg.sv
rtl/core/eltok_scan.sv
rtl/core/eltok_queue.sv
rtl/core/expression_language_tokenizer_top.sv
rtl/core/eltok_checker.sv
sim/eltok_token_checker.sv
sim/expression_language_tokenizer_top_tb.sv
